[hw/rtl/stm_pkg.sv]
package stm_pkg;

   // item kinds carried in the low bits of req_tuser
   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READING = 2'd1,
      OP_ROUND   = 2'd2
   } op_type;

   // slot setting picked by a write word
   typedef enum logic [2:0] {
      SEL_UPPER_TRIG = 3'd0,
      SEL_UPPER_RST  = 3'd1,
      SEL_LOWER_TRIG = 3'd2,
      SEL_LOWER_RST  = 3'd3,
      SEL_BINDING    = 3'd4
   } sel_type;

   // threshold index, also the bit position of its enable
   localparam logic [1:0] THR_UPPER_TRIG = 2'd0;
   localparam logic [1:0] THR_UPPER_RST  = 2'd1;
   localparam logic [1:0] THR_LOWER_TRIG = 2'd2;
   localparam logic [1:0] THR_LOWER_RST  = 2'd3;

   localparam int BIND_W = 6;
   localparam int CNT_W  = 8;

   localparam logic [CNT_W-1:0] CNT_MAX     = 8'hFF;
   localparam logic [7:0]       LIMIT_RESET = 8'd10;

   // settings of the addressed slot
   typedef struct packed {
      logic [3:0]        en;
      logic [BIND_W-1:0] binding;
      logic              off;
      logic [CNT_W-1:0]  cnt;
   } slot_ctl_type;

   // update of the addressed slot
   typedef struct packed {
      logic             thr_we;
      logic [1:0]       thr_sel;
      logic             en_we;
      logic             en_val;
      logic             bind_we;
      logic             off_we;
      logic             off_val;
      logic             cnt_we;
      logic [CNT_W-1:0] cnt_val;
   } slot_wr_type;

   // command to the trip state
   typedef struct packed {
      logic upd;
      logic trip;
      logic rst;
      logic round;
   } trip_cmd_type;

   // trip state as left by the current word
   typedef struct packed {
      logic sensor_bit;
      logic any;
      logic reprogram;
      logic done;
   } trip_sts_type;

endpackage

[hw/rtl/stm_slot_table.sv]
module stm_slot_table
   import stm_pkg::*;
#(
   parameter int SLOTS = 16,
   parameter int VW    = 32,
   parameter int SIW   = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [SIW-1:0]           idx,
   input  slot_wr_type              wr,
   input  logic signed [VW-1:0]     wr_value,
   input  logic [BIND_W-1:0]        wr_binding,
   output slot_ctl_type             rd_ctl,
   output logic signed [VW-1:0]     rd_upper_trig,
   output logic signed [VW-1:0]     rd_upper_rst,
   output logic signed [VW-1:0]     rd_lower_trig,
   output logic signed [VW-1:0]     rd_lower_rst
);

   logic signed [VW-1:0] upper_trig_ff [SLOTS];
   logic signed [VW-1:0] upper_rst_ff  [SLOTS];
   logic signed [VW-1:0] lower_trig_ff [SLOTS];
   logic signed [VW-1:0] lower_rst_ff  [SLOTS];
   logic [BIND_W-1:0]    binding_ff    [SLOTS];
   logic [3:0]           en_ff         [SLOTS];
   logic                 off_ff        [SLOTS];
   logic [CNT_W-1:0]     cnt_ff        [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            en_ff[i]  <= '0;
            off_ff[i] <= 1'b1;
            cnt_ff[i] <= '0;
         end
      end else begin
         if (wr.en_we) begin
            en_ff[idx][wr.thr_sel] <= wr.en_val;
         end
         if (wr.off_we) begin
            off_ff[idx] <= wr.off_val;
         end
         if (wr.cnt_we) begin
            cnt_ff[idx] <= wr.cnt_val;
         end
      end
   end

   // thresholds and binding hold garbage until written
   always_ff @(posedge clock) begin
      if (wr.thr_we) begin
         case (wr.thr_sel)
            THR_UPPER_TRIG: upper_trig_ff[idx] <= wr_value;
            THR_UPPER_RST:  upper_rst_ff[idx]  <= wr_value;
            THR_LOWER_TRIG: lower_trig_ff[idx] <= wr_value;
            default:        lower_rst_ff[idx]  <= wr_value;
         endcase
      end
      if (wr.bind_we) begin
         binding_ff[idx] <= wr_binding;
      end
   end

   always_comb begin
      rd_ctl.en      = en_ff[idx];
      rd_ctl.binding = binding_ff[idx];
      rd_ctl.off     = off_ff[idx];
      rd_ctl.cnt     = cnt_ff[idx];
      rd_upper_trig  = upper_trig_ff[idx];
      rd_upper_rst   = upper_rst_ff[idx];
      rd_lower_trig  = lower_trig_ff[idx];
      rd_lower_rst   = lower_rst_ff[idx];
   end

endmodule

[hw/rtl/stm_trip_state.sv]
module stm_trip_state
   import stm_pkg::*;
#(
   parameter int SENSORS = 64,
   parameter int SNW     = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  trip_cmd_type   cmd,
   input  logic [SNW-1:0] sn,
   output trip_sts_type   sts
);

   logic [SENSORS-1:0] trip_ff, trip_in;
   logic [SENSORS-1:0] last_ff, last_in;
   logic               rise_ff, rise_in;
   logic               clear_ff, clear_in;
   logic               done_ff, done_in;
   logic               reprogram;

   always_comb begin
      trip_in   = trip_ff;
      last_in   = last_ff;
      rise_in   = rise_ff;
      clear_in  = clear_ff;
      done_in   = done_ff;
      reprogram = 1'b0;
      if (cmd.upd) begin
         // reset wins over trip
         if (cmd.rst) begin
            trip_in[sn] = 1'b0;
         end else if (cmd.trip) begin
            trip_in[sn] = 1'b1;
         end
         if (cmd.trip && !last_ff[sn]) begin
            rise_in = 1'b1;
         end
         if (cmd.rst && last_ff[sn]) begin
            clear_in = 1'b1;
         end
      end
      if (cmd.round) begin
         if (rise_ff) begin
            reprogram = !done_ff;
            done_in   = 1'b1;
         end else if (clear_ff && (trip_ff == '0)) begin
            done_in = 1'b0;
         end
         last_in  = trip_ff;
         rise_in  = 1'b0;
         clear_in = 1'b0;
      end
      sts.sensor_bit = trip_in[sn];
      sts.any        = |trip_in;
      sts.reprogram  = reprogram;
      sts.done       = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trip_ff  <= '0;
         last_ff  <= '0;
         rise_ff  <= 1'b0;
         clear_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         trip_ff  <= trip_in;
         last_ff  <= last_in;
         rise_ff  <= rise_in;
         clear_ff <= clear_in;
         done_ff  <= done_in;
      end
   end

endmodule

[hw/rtl/sensor_threshold_trip_monitor.sv]
// an accepted request word passes through the input register and then the response
// register to rsp_tvalid; throughput: one word per cycle while rsp_tready holds, with
// a single pass of table read, compare and trip update between the two registers
// reset: synchronous, active high; clears enables, invalid counts, trip state and
// pending flags, marks every slot unbound and loads disable_limit with 10
// thresholds and sensor bindings are not cleared and hold garbage until written
module sensor_threshold_trip_monitor
   import stm_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int SENSORS    = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // slot[3:0], value[35:4], zero pad[39:36]
   input  logic [5:0]  req_tuser,   // op[1:0], setting_select[4:2], flag[5]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // reprogram[0], any_tripped[1], sensor_tripped[2],
                                    // slot_disabled[3], programmed[4], zero pad[7:5]
   // disable_limit write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   // stored threshold width: values arrive sign extended from at most 32 bits
   localparam int VW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SNW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

   // ---------------------------------------------------------------------------------
   // config register
   // ---------------------------------------------------------------------------------
   logic [7:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   // ---------------------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------------------
   logic               in_valid_ff, in_valid_in;
   logic [1:0]         op_ff;
   logic [3:0]         slot_ff;
   logic [2:0]         sel_ff;
   logic signed [31:0] value_ff;
   logic               flag_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic advance;
   logic req_take;

   // the word in the input register moves on when the response slot is free or drains
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_tuser[1:0];
         sel_ff   <= req_tuser[4:2];
         flag_ff  <= req_tuser[5];
         slot_ff  <= req_tdata[3:0];
         value_ff <= req_tdata[35:4];
      end
   end

   // ---------------------------------------------------------------------------------
   // slot table
   // ---------------------------------------------------------------------------------
   logic [SIW-1:0]        idx;
   slot_wr_type           slot_wr;
   slot_ctl_type          ctl;
   logic signed [VW-1:0]  v;
   logic signed [VW-1:0]  upper_trig, upper_rst, lower_trig, lower_rst;

   assign idx = SIW'(slot_ff);
   assign v   = value_ff[VW-1:0];

   stm_slot_table #(
      .SLOTS (SLOTS),
      .VW    (VW),
      .SIW   (SIW)
   ) u_slot_table (
      .clock         (clock),
      .reset         (reset),
      .idx           (idx),
      .wr            (slot_wr),
      .wr_value      (v),
      .wr_binding    (value_ff[BIND_W-1:0]),
      .rd_ctl        (ctl),
      .rd_upper_trig (upper_trig),
      .rd_upper_rst  (upper_rst),
      .rd_lower_trig (lower_trig),
      .rd_lower_rst  (lower_rst)
   );

   // ---------------------------------------------------------------------------------
   // evaluation of the word in the input register
   // ---------------------------------------------------------------------------------
   trip_cmd_type     trip_cmd;
   trip_sts_type     trip_sts;
   logic [SNW-1:0]   sn;
   logic             slot_ok;
   logic             bind_ok;
   logic             trip_hit;
   logic             rst_hit;
   logic [CNT_W-1:0] cnt_next;
   logic             slot_disabled;
   logic             sensor_tripped;

   assign sn      = SNW'(ctl.binding);
   assign slot_ok = 32'(slot_ff) < 32'(SLOTS);
   assign bind_ok = flag_ff && ($unsigned(value_ff) < 32'(SENSORS));

   // hysteresis: a disabled trigger never fires, a disabled reset always holds
   assign trip_hit = (ctl.en[THR_UPPER_TRIG] && (v > upper_trig)) ||
                     (ctl.en[THR_LOWER_TRIG] && (v < lower_trig));
   assign rst_hit  = (!ctl.en[THR_UPPER_RST] || (v < upper_rst)) &&
                     (!ctl.en[THR_LOWER_RST] || (v > lower_rst));

   // invalid read count saturates
   assign cnt_next = (ctl.cnt == CNT_MAX) ? CNT_MAX : ctl.cnt + 1'b1;

   always_comb begin
      slot_wr        = '0;
      trip_cmd       = '0;
      slot_disabled  = 1'b0;
      sensor_tripped = 1'b0;
      case (op_ff)
         OP_WRITE: begin
            if (!slot_ok) begin
               slot_disabled = 1'b1;
            end else if (sel_ff == SEL_BINDING) begin
               slot_wr.off_we  = advance;
               slot_wr.off_val = !bind_ok;
               slot_wr.bind_we = advance && bind_ok;
               slot_wr.cnt_we  = advance && bind_ok;
               slot_wr.cnt_val = '0;
               slot_disabled   = !bind_ok;
            end else begin
               // threshold writes carry their enable; unknown selects do nothing
               slot_wr.thr_sel = sel_ff[1:0];
               slot_wr.thr_we  = advance && !sel_ff[2];
               slot_wr.en_we   = advance && !sel_ff[2];
               slot_wr.en_val  = flag_ff;
               slot_disabled   = ctl.off;
            end
         end
         OP_READING: begin
            if (!slot_ok || ctl.off) begin
               slot_disabled = 1'b1;
            end else if (!flag_ff) begin
               // invalid read: count it, switch off past the limit, trip bit untouched
               slot_wr.cnt_we  = advance;
               slot_wr.cnt_val = cnt_next;
               slot_wr.off_we  = advance;
               slot_wr.off_val = cnt_next > limit_ff;
               slot_disabled   = cnt_next > limit_ff;
               sensor_tripped  = trip_sts.sensor_bit;
            end else begin
               trip_cmd.upd   = advance;
               trip_cmd.trip  = trip_hit;
               trip_cmd.rst   = rst_hit;
               sensor_tripped = trip_sts.sensor_bit;
            end
         end
         OP_ROUND: begin
            trip_cmd.round = advance;
         end
         default: begin
         end
      endcase
   end

   stm_trip_state #(
      .SENSORS (SENSORS),
      .SNW     (SNW)
   ) u_trip_state (
      .clock (clock),
      .reset (reset),
      .cmd   (trip_cmd),
      .sn    (sn),
      .sts   (trip_sts)
   );

   // ---------------------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------------------
   always_comb begin
      rsp_data_in = {3'b000, trip_sts.done, slot_disabled, sensor_tripped,
                     trip_sts.any, trip_sts.reprogram};
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------

   // a reprogram request always leaves the done flag set
   a_reprogram_sets_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[0] |-> rsp_data_ff[4])
      else $error("reprogram without programmed");

   // a tripped sensor means some trip bit is set
   a_sensor_implies_any: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[2] |-> rsp_data_ff[1])
      else $error("sensor tripped without any tripped");

   // a held word in the input register is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_take)
      else $error("input register overwritten");

   // a word that leaves the input register shows up as a response next cycle
   a_advance_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word lost");

endmodule

[dv/trip_monitor_checker.sv]
`timescale 1ns / 100ps

module trip_monitor_checker
   import stm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [5:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          words_pending
);

   localparam int SLOTS       = 16;
   localparam int SENSORS     = 64;

   // same bit order as rsp_tdata[4:0]
   typedef struct packed {
      logic programmed;
      logic slot_disabled;
      logic sensor_tripped;
      logic any_tripped;
      logic reprogram;
   } trip_status_type;

   logic signed [31:0] upper_trig [SLOTS];
   logic signed [31:0] upper_rst  [SLOTS];
   logic signed [31:0] lower_trig [SLOTS];
   logic signed [31:0] lower_rst  [SLOTS];
   logic [3:0]         thr_en       [SLOTS];
   logic [BIND_W-1:0]  bound_sensor [SLOTS];
   logic               slot_is_off  [SLOTS];
   logic [CNT_W-1:0]   bad_reads    [SLOTS];
   logic [SENSORS-1:0] trip_now;
   logic [SENSORS-1:0] trip_last;
   logic               rise_seen;
   logic               clear_seen;
   logic               fallback_done;
   logic [7:0]         trip_limit;

   trip_status_type expected_status_q [$];

   // advances the mirrored state by one request word
   function automatic trip_status_type predict_status(op_type op, logic [3:0] slot,
         logic [2:0] sel, logic signed [31:0] val, logic flag);
      trip_status_type st;
      logic trip_hit;
      logic reset_hit;
      logic [BIND_W-1:0] sn;
      st = '0;
      case (op)
         OP_WRITE: begin
            case (sel)
               SEL_UPPER_TRIG: upper_trig[slot] = val;
               SEL_UPPER_RST:  upper_rst[slot]  = val;
               SEL_LOWER_TRIG: lower_trig[slot] = val;
               SEL_LOWER_RST:  lower_rst[slot]  = val;
               SEL_BINDING: begin
                  if (flag && $unsigned(val) < SENSORS) begin
                     bound_sensor[slot] = val[BIND_W-1:0];
                     slot_is_off[slot]  = 1'b0;
                     bad_reads[slot]    = '0;
                  end else begin
                     slot_is_off[slot] = 1'b1;
                  end
               end
               default: ;
            endcase
            if (sel <= SEL_LOWER_RST) thr_en[slot][sel[1:0]] = flag;
            st.slot_disabled = slot_is_off[slot];
         end
         OP_READING: begin
            if (slot_is_off[slot]) begin
               st.slot_disabled = 1'b1;
            end else begin
               sn = bound_sensor[slot];
               if (!flag) begin
                  if (bad_reads[slot] != CNT_MAX) bad_reads[slot]++;
                  if (bad_reads[slot] > trip_limit) slot_is_off[slot] = 1'b1;
               end else begin
                  trip_hit = (thr_en[slot][THR_UPPER_TRIG] && val > upper_trig[slot]) ||
                             (thr_en[slot][THR_LOWER_TRIG] && val < lower_trig[slot]);
                  // a disabled reset side counts as met
                  reset_hit = (!thr_en[slot][THR_UPPER_RST] || val < upper_rst[slot]) &&
                              (!thr_en[slot][THR_LOWER_RST] || val > lower_rst[slot]);
                  if (trip_hit) begin
                     trip_now[sn] = 1'b1;
                     if (!trip_last[sn]) rise_seen = 1'b1;
                  end
                  if (reset_hit) begin
                     trip_now[sn] = 1'b0;
                     if (trip_last[sn]) clear_seen = 1'b1;
                  end
               end
               st.sensor_tripped = trip_now[sn];
               st.slot_disabled  = slot_is_off[slot];
            end
         end
         OP_ROUND: begin
            if (rise_seen) st.reprogram = !fallback_done;
            else if (clear_seen && trip_now == '0) fallback_done = 1'b0;
            if (st.reprogram) fallback_done = 1'b1;
            trip_last  = trip_now;
            rise_seen  = 1'b0;
            clear_seen = 1'b0;
         end
         default: ;
      endcase
      st.any_tripped = |trip_now;
      st.programmed  = fallback_done;
      return st;
   endfunction

   task automatic check_field(string name, logic want, logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %b, actual %b", $realtime, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      trip_status_type want;
      trip_status_type got;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            thr_en[i]      = '0;
            slot_is_off[i] = 1'b1;
            bad_reads[i]   = '0;
         end
         trip_now      = '0;
         trip_last     = '0;
         rise_seen     = 1'b0;
         clear_seen    = 1'b0;
         fallback_done = 1'b0;
         trip_limit    = LIMIT_RESET;
         expected_status_q.delete();
      end else begin
         if (csr_valid && csr_ready) trip_limit = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h",
                        $realtime, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_status_q.pop_front();
               got  = trip_status_type'(rsp_tdata[4:0]);
               check_field("reprogram", want.reprogram, got.reprogram);
               check_field("any_tripped", want.any_tripped, got.any_tripped);
               check_field("sensor_tripped", want.sensor_tripped, got.sensor_tripped);
               check_field("slot_disabled", want.slot_disabled, got.slot_disabled);
               check_field("programmed", want.programmed, got.programmed);
               check_field("pad bit 5", 1'b0, rsp_tdata[5]);
               check_field("pad bit 6", 1'b0, rsp_tdata[6]);
               check_field("pad bit 7", 1'b0, rsp_tdata[7]);
            end
         end
         if (req_tvalid && req_tready)
            expected_status_q.push_back(predict_status(op_type'(req_tuser[1:0]),
               req_tdata[3:0], req_tuser[4:2], req_tdata[35:4], req_tuser[5]));
      end
      words_pending <= expected_status_q.size();
   end

endmodule

[dv/sensor_threshold_trip_monitor_test.sv]
`timescale 1ns / 100ps

module sensor_threshold_trip_monitor_test;
   import stm_pkg::*;

   // op code that the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SENSORS     = 64;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // slot[3:0], value[35:4], zero pad[39:36]
   logic [5:0]  req_tuser = '0;   // op[1:0], setting_select[4:2], flag[5]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // reprogram[0], any_tripped[1], sensor_tripped[2],
                                  // slot_disabled[3], programmed[4], zero pad[7:5]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   int fail_count;
   int words_pending;
   int cycle_count  = 0;
   int tx_idle_pct  = 0;   // chance per cycle that the sender holds back a word
   int rx_stall_pct = 0;   // chance per cycle that the receiver drops tready
   bit hold_req     = 1'b0;
   bit hold_done    = 1'b0;
   int hold_left    = 0;

   sensor_threshold_trip_monitor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // watches all three channels and predicts every response word
   trip_monitor_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sensor_threshold_trip_monitor_test: FAIL");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // offers one request word, called and returning at a falling edge;
   // tvalid is left high so back-to-back words stay continuous
   task automatic send_word(logic [1:0] op, logic [3:0] slot, logic [2:0] sel,
                            logic [31:0] val, logic flag);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, val, slot};
      req_tuser  <= {flag, sel, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(logic [7:0] limit);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop tvalid and let every outstanding response drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // readings mostly within 4000 of zero where the thresholds sit
   function automatic logic [31:0] pick_reading();
      if ($urandom_range(99) < 85) return 32'(int'($urandom_range(8000)) - 4000);
      return $urandom;
   endfunction

   // thresholds placed so that trigger and reset form a hysteresis band
   function automatic logic [31:0] pick_threshold(logic [2:0] sel);
      int base;
      case (sel)
         SEL_UPPER_TRIG: base = 1000;
         SEL_UPPER_RST:  base = 0;
         SEL_LOWER_TRIG: base = -3000;
         default:        base = -2000;
      endcase
      if ($urandom_range(99) < 15) return $urandom;
      return 32'(base + int'($urandom_range(2000)));
   endfunction

   task automatic send_random_word();
      int pick;
      int kind;
      logic [2:0] sel;
      logic [31:0] sensor;
      pick = $urandom_range(99);
      kind = $urandom_range(99);
      if (pick < 8) begin
         send_word(OP_ROUND, 4'($urandom), 3'($urandom), $urandom, 1'($urandom));
      end else if (pick < 10) begin
         send_word(OP_UNUSED, 4'($urandom), 3'($urandom), $urandom, 1'($urandom));
      end else if (pick < 30) begin
         if (kind < 30) begin
            // bindings favor a few sensors so that slots share trip bits
            if ($urandom_range(9) == 0) sensor = $urandom;
            else if ($urandom_range(3) == 0) sensor = $urandom_range(SENSORS - 1);
            else sensor = $urandom_range(7);
            send_word(OP_WRITE, 4'($urandom), SEL_BINDING, sensor,
                      $urandom_range(9) != 0);
         end else if (kind < 95) begin
            sel = 3'($urandom_range(SEL_LOWER_RST));
            send_word(OP_WRITE, 4'($urandom), sel, pick_threshold(sel),
                      $urandom_range(99) < 85);
         end else begin
            send_word(OP_WRITE, 4'($urandom), 3'($urandom_range(7, SEL_BINDING + 1)),
                      $urandom, 1'($urandom));
         end
      end else begin
         send_word(OP_READING, 4'($urandom), 3'($urandom), pick_reading(),
                   $urandom_range(99) >= 6);
      end
   endtask

   task automatic run_phase(logic [7:0] limit, int tx_pct, int rx_pct, int count);
      wait_idle();
      write_limit(limit);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      repeat (count) send_random_word();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: bindings, hysteresis, extremes, ignored words
      send_word(OP_WRITE,   4'd0,  SEL_BINDING,    32'd0,  1'b1);
      send_word(OP_WRITE,   4'd15, SEL_BINDING,    32'd63, 1'b1);
      send_word(OP_WRITE,   4'd1,  SEL_BINDING,    32'd64, 1'b1);  // sensor out of range
      send_word(OP_WRITE,   4'd0,  SEL_UPPER_TRIG, 32'd1000, 1'b1);
      send_word(OP_WRITE,   4'd0,  SEL_UPPER_RST,  32'd500,  1'b1);
      send_word(OP_WRITE,   4'd0,  SEL_LOWER_TRIG, -32'sd1000, 1'b1);
      send_word(OP_WRITE,   4'd0,  SEL_LOWER_RST,  -32'sd500,  1'b1);
      send_word(OP_READING, 4'd0,  SEL_UPPER_TRIG, 32'd2000, 1'b1);  // trips
      send_word(OP_READING, 4'd0,  SEL_UPPER_TRIG, 32'd700,  1'b1);  // inside the band
      send_word(OP_ROUND,   4'd0,  SEL_UPPER_TRIG, 32'd0,    1'b0);  // asks for reprogram
      send_word(OP_READING, 4'd0,  SEL_UPPER_TRIG, -32'sd2000, 1'b1);
      send_word(OP_READING, 4'd0,  SEL_UPPER_TRIG, 32'd0,    1'b1);  // clears
      send_word(OP_ROUND,   4'd0,  SEL_UPPER_TRIG, 32'd0,    1'b0);  // re-arms
      // minimum trigger, both reset sides disabled: trip and reset together
      send_word(OP_WRITE,   4'd15, SEL_UPPER_TRIG, 32'h8000_0000, 1'b1);
      send_word(OP_READING, 4'd15, SEL_UPPER_TRIG, 32'h7FFF_FFFF, 1'b1);
      send_word(OP_WRITE,   4'd15, SEL_UPPER_RST,  32'h7FFF_FFFF, 1'b1);
      send_word(OP_READING, 4'd15, SEL_UPPER_TRIG, 32'h7FFF_FFFF, 1'b1);
      send_word(OP_WRITE,   4'd0,  3'd5,           32'h1234_5678, 1'b0);
      send_word(OP_WRITE,   4'd0,  3'd7,           32'hFFFF_FFFF, 1'b1);
      send_word(OP_READING, 4'd2,  SEL_UPPER_TRIG, 32'd0,    1'b1);  // unbound slot
      send_word(OP_READING, 4'd0,  SEL_UPPER_TRIG, 32'd0,    1'b0);  // invalid reading
      send_word(OP_UNUSED,  4'd15, 3'd7,           32'hFFFF_FFFF, 1'b1);
      send_word(OP_ROUND,   4'd0,  SEL_UPPER_TRIG, 32'd0,    1'b0);
      send_word(OP_WRITE,   4'd15, SEL_BINDING,    32'd63,   1'b0);  // unbind
      send_word(OP_READING, 4'd15, SEL_UPPER_TRIG, 32'd0,    1'b1);

      // lowest limit, no idling; one long receiver hold-off fills the pipe
      wait_idle();
      write_limit(8'd0);
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      for (int i = 0; i < 450; i++) begin
         if (i == 100) hold_req = 1'b1;
         send_random_word();
      end

      // limit of 254 with a sender that idles; a run of invalid reads
      // drives one slot's count all the way up
      run_phase(8'd254, 72, 0, 200);
      send_word(OP_WRITE, 4'd3, SEL_BINDING, 32'd5, 1'b1);
      repeat (256) send_word(OP_READING, 4'd3, 3'($urandom), $urandom, 1'b0);

      run_phase(8'($urandom_range(30, 1)), 0, 72, 450);
      run_phase(8'd6, 35, 35, 450);

      rx_stall_pct = 0;
      wait_idle();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("sensor_threshold_trip_monitor_test: PASS");
      end else begin
         $display("sensor_threshold_trip_monitor_test: FAIL");
      end
      $finish;
   end

endmodule

[sensor_threshold_trip_monitor.f]
hw/rtl/stm_pkg.sv
hw/rtl/stm_slot_table.sv
hw/rtl/stm_trip_state.sv
hw/rtl/sensor_threshold_trip_monitor.sv
dv/trip_monitor_checker.sv
dv/sensor_threshold_trip_monitor_test.sv
